FILE: sv/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg: shared types and constants for the delimited frame extractor
// Holds the default frame limit, register reset values and index codes, and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

    // Byte width of every word on the link
    localparam int BYTE_W = 8;

    // Default frame buffer depth in bytes
    localparam int MAX_FRAME_DEF = 32;

    // Configuration register index width and codes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_DELIM   = 2'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_DELIM_RST   = 8'h03;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_first;   // store the opening delimiter at entry zero, length one
        logic wr_append;  // store the word at the current length, bump length
        logic rd_clear;   // rewind the readout index
        logic rd_issue;   // read the buffer at the readout index
        logic rd_next;    // advance the readout index
        logic load_out;   // move read data into the output register
    } dfe_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_start;   // incoming word matches the start delimiter
        logic is_end;     // incoming word matches the end delimiter
        logic is_full;    // appending this word fills the buffer
        logic rd_last;    // readout index is on the final stored byte
        logic out_free;   // output register is empty or being taken
    } dfe_status_t;

endpackage

`default_nettype wire

FILE: sv/dfe_if.sv
// ----------------------------------------------------------------------------
// dfe_if: valid/ready channels of the delimited frame extractor
// Received byte channel, frame byte channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfe_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface dfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dfe_ram.sv
// ----------------------------------------------------------------------------
// dfe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/dfe_ctrl.sv
// ----------------------------------------------------------------------------
// dfe_ctrl: frame extractor controller
// Hunts for the start delimiter, collects the frame, then sequences the
// readout of the buffer into the output register one byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire dfe_pkg::dfe_status_t status,
    output dfe_pkg::dfe_cmd_t         cmd
);

    import dfe_pkg::*;

    localparam logic [1:0] S_HUNT    = 2'd0;
    localparam logic [1:0] S_COLLECT = 2'd1;
    localparam logic [1:0] S_READ    = 2'd2;
    localparam logic [1:0] S_LOAD    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Accept words only while hunting or collecting
    assign in_ready = (state_reg == S_HUNT) || (state_reg == S_COLLECT);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_HUNT:
            begin
                if (in_valid && status.is_start)
                begin
                    cmd.wr_first = 1'b1;
                    state_next   = S_COLLECT;
                end
            end
            S_COLLECT:
            begin
                if (in_valid)
                begin
                    cmd.wr_append = 1'b1;
                    if (status.is_end)
                    begin
                        cmd.rd_clear = 1'b1;
                        state_next   = S_READ;
                    end
                    else if (status.is_full)
                    begin
                        // drop the frame silently
                        state_next = S_HUNT;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/dfe_datapath.sv
// ----------------------------------------------------------------------------
// dfe_datapath: frame extractor datapath
// Delimiter registers, frame buffer, length and readout counters, and the
// output register that holds one frame byte for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_datapath #(
    parameter int MAX_FRAME = dfe_pkg::MAX_FRAME_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dfe_pkg::BYTE_W-1:0]      cfg_data,
    input  wire logic [dfe_pkg::BYTE_W-1:0]      rx_byte,
    input  wire dfe_pkg::dfe_cmd_t               cmd,
    output dfe_pkg::dfe_status_t                 status,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [dfe_pkg::BYTE_W-1:0]      frame_byte,
    output logic                                 frame_last
);

    import dfe_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int LW = $clog2(MAX_FRAME + 1);

    logic [BYTE_W-1:0] start_delim_reg;
    logic [BYTE_W-1:0] end_delim_reg;
    logic [LW-1:0]     len_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delim_reg <= START_DELIM_RST;
            end_delim_reg   <= END_DELIM_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_START_DELIM)
            begin
                start_delim_reg <= cfg_data;
            end
            else if (cfg_index == REG_END_DELIM)
            begin
                end_delim_reg <= cfg_data;
            end
        end
    end

    // Frame buffer writes: opening delimiter at zero, then at the length
    assign ram_we    = cmd.wr_first || cmd.wr_append;
    assign ram_waddr = cmd.wr_first ? '0 : len_reg[AW-1:0];

    dfe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Length and readout counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (cmd.wr_first)
            begin
                len_reg <= LW'(1);
            end
            else if (cmd.wr_append)
            begin
                len_reg <= len_reg + LW'(1);
            end
            if (cmd.rd_clear)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
        end
    end

    // Output register: hold until taken, reload from the buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg <= ram_rdata;
            out_last_reg <= status.rd_last;
        end
    end

    // Status back to the controller
    assign status.is_start = (rx_byte == start_delim_reg);
    assign status.is_end   = (rx_byte == end_delim_reg);
    assign status.is_full  = (len_reg == LW'(MAX_FRAME - 1));
    assign status.rd_last  = ((LW'(rd_idx_reg) + LW'(1)) == len_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_last = out_last_reg;

endmodule

`default_nettype wire

FILE: sv/delimited_frame_extractor.sv
// ----------------------------------------------------------------------------
// delimited_frame_extractor: start/end delimited frame extractor
// Pulls frames out of a received byte stream and replays each whole frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : received words, one byte each. While hunting, words other than the
//         start delimiter are dropped; a start delimiter opens a frame.
//   frm : frame words, delimiters included, frame_last set on the end
//         delimiter. A frame that fills MAX_FRAME bytes without an end
//         delimiter is dropped and never shows up here.
//   cfg : register writes (index 0 start delimiter, index 1 end delimiter),
//         always ready; write only while the block is idle.
// Timing: after the end delimiter the frame is read back from the buffer one
//   byte at a time, each byte a buffer read (S_READ) then an output load
//   (S_LOAD); rx is not ready during the readout. The first frame byte is
//   valid once S_READ and S_LOAD have run after the end delimiter is taken.
// Stall: a stalled receiver holds the output register and the readout waits;
//   once the last byte is loaded rx is ready again even if it is not yet taken.
// Reset: delimiters return to 0x02 and 0x03, the block hunts, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_frame_extractor #(
    parameter int MAX_FRAME = dfe_pkg::MAX_FRAME_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dfe_byte_if.sink   rx,
    dfe_frame_if.source frm,
    dfe_cfg_if.sink    cfg
);

    import dfe_pkg::*;

    dfe_cmd_t    cmd;
    dfe_status_t status;
    logic        rx_ready;

    // Configuration channel never stalls
    assign cfg.ready = 1'b1;
    assign rx.ready  = rx_ready;

    dfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dfe_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .rx_byte    (rx.rx_byte),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (frm.valid),
        .out_ready  (frm.ready),
        .frame_byte (frm.frame_byte),
        .frame_last (frm.frame_last)
    );

endmodule

`default_nettype wire

FILE: tb/delimited_frame_extractor_tb.sv
// ----------------------------------------------------------------------------
// delimited_frame_extractor_tb: self-checking bench for the frame extractor
// Feeds received words (noise, closed frames, full-length frames and overrun
// frames) under several delimiter settings, with random gaps on the receive
// side and random stalls on the frame side. A scoreboard rebuilds every
// completed frame and checks each frame word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module delimited_frame_extractor_tb;

    import dfe_pkg::*;

    localparam int FRAME_MAX   = MAX_FRAME_DEF;
    localparam int PHASE_WORDS = 77;
    localparam int DRAIN_CYCLES = 10;

    // Register indexes past the two delimiters; writes there are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_word_t;

    // Tracks delimiters and the open frame, queues the words of each frame
    class frame_scoreboard;
        logic [BYTE_W-1:0] start_delim;
        logic [BYTE_W-1:0] end_delim;
        bit                collecting;
        int unsigned       frame_len;
        logic [BYTE_W-1:0] frame_buf [FRAME_MAX];
        frame_word_t       pending_words [$];
        int unsigned       fail_count;

        function new();
            start_delim = START_DELIM_RST;
            end_delim   = END_DELIM_RST;
            collecting  = 1'b0;
            frame_len   = 0;
            fail_count  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                REG_START_DELIM: start_delim = val;
                REG_END_DELIM:   end_delim = val;
                default:         ;
            endcase
        endfunction

        // Advance the frame state by one accepted received word
        function void note_rx(logic [BYTE_W-1:0] b);
            frame_word_t w;
            if (!collecting) begin
                if (b == start_delim) begin
                    frame_buf[0] = b;
                    frame_len    = 1;
                    collecting   = 1'b1;
                end
                return;
            end
            if (frame_len >= FRAME_MAX) begin
                collecting = 1'b0;
                frame_len  = 0;
                return;
            end
            frame_buf[frame_len] = b;
            frame_len++;
            if (b == end_delim) begin
                for (int i = 0; i < frame_len; i++) begin
                    w.data = frame_buf[i];
                    w.last = (i + 1 == frame_len);
                    pending_words = {pending_words, w};
                end
                collecting = 1'b0;
                frame_len  = 0;
            end else if (frame_len >= FRAME_MAX) begin
                // drop the overrun frame silently
                collecting = 1'b0;
                frame_len  = 0;
            end
        endfunction

        // Compare one accepted frame word with the oldest expected one
        function void check_word(logic [BYTE_W-1:0] data, logic last);
            frame_word_t w;
            if (pending_words.size() == 0) begin
                $error("unexpected frame word: frame_byte=%02h frame_last=%0b", data, last);
                fail_count++;
                return;
            end
            w = pending_words.pop_front();
            if (data !== w.data) begin
                $error("frame_byte mismatch: expected %02h, got %02h", w.data, data);
                fail_count++;
            end
            if (last !== w.last) begin
                $error("frame_last mismatch: expected %0b, got %0b", w.last, last);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dfe_byte_if  rx_if ();
    dfe_frame_if frm_if ();
    dfe_cfg_if   cfg_if ();

    delimited_frame_extractor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frm   (frm_if),
        .cfg   (cfg_if)
    );

    frame_scoreboard sb = new();

    bit rx_idle_on  = 1'b1;
    bit frm_idle_on = 1'b1;
    int frame_words;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int draw_gap(bit on);
        return on ? int'($urandom_range(0, 12)) : 0;
    endfunction

    // Frame content: never the end delimiter, sometimes the start delimiter
    function automatic logic [BYTE_W-1:0] body_word();
        logic [BYTE_W-1:0] b;
        if (sb.start_delim != sb.end_delim && $urandom_range(0, 7) == 0)
            return sb.start_delim;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == sb.end_delim);
        return b;
    endfunction

    // Noise seen while hunting: never the start delimiter, sometimes the end one
    function automatic logic [BYTE_W-1:0] noise_word();
        logic [BYTE_W-1:0] b;
        if (sb.start_delim != sb.end_delim && $urandom_range(0, 5) == 0)
            return sb.end_delim;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == sb.start_delim);
        return b;
    endfunction

    // Send one received word; called and returns at a falling edge
    task automatic send_word(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_gap(rx_idle_on);
        if (gap > 0)
        begin
            rx_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge clk); while (!rx_if.ready);
        sb.note_rx(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input int body_len, input bit closed);
        send_word(sb.start_delim);
        repeat (body_len) send_word(body_word());
        if (closed)
            send_word(sb.end_delim);
        frame_words += body_len + 1 + int'(closed);
    endtask

    // Hold rx idle until every frame word is out, then let the block settle
    task automatic settle();
        rx_if.valid = 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge clk); while (!cfg_if.ready);
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        write_reg(REG_SPARE_2, BYTE_W'($urandom_range(0, 255)));
        write_reg(REG_START_DELIM, s);
        write_reg(REG_END_DELIM, e);
        write_reg(REG_SPARE_3, BYTE_W'($urandom_range(0, 255)));
        cfg_if.valid = 1'b0;
    endtask

    // Mostly well-formed frames, with full-length, overrun and noise mixed in
    task automatic run_phase(input int target);
        int pick;
        frame_words = 0;
        while (frame_words < target)
        begin
            if ($urandom_range(0, 7) == 0)
                rx_idle_on = !rx_idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame($urandom_range(0, 6), 1'b1);
            else if (pick < 80)
                send_frame($urandom_range(7, FRAME_MAX - 3), 1'b1);
            else if (pick < 88)
                send_frame(FRAME_MAX - 2, 1'b1);
            else if (pick < 94)
                send_frame(FRAME_MAX - 1, 1'b0);
            else
                repeat ($urandom_range(1, 4)) send_word(noise_word());
        end
    endtask

    // Frame side: stall at random, check every accepted word
    initial
    begin : frame_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(frm_idle_on);
            if (stall > 0)
            begin
                frm_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            frm_if.ready = 1'b1;
            do @(posedge clk); while (!frm_if.valid);
            sb.check_word(frm_if.frame_byte, frm_if.frame_last);
            if ($urandom_range(0, 29) == 0)
                frm_idle_on = !frm_idle_on;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [BYTE_W-1:0] start_tab [5];
        logic [BYTE_W-1:0] end_tab   [5];

        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        frm_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        start_tab      = '{8'h00, 8'hFF, 8'h7E, 8'h55, 8'h00};
        end_tab        = '{8'hFF, 8'h00, 8'h7E, 8'hAA, 8'h00};
        start_tab[4]   = BYTE_W'($urandom_range(0, 255));
        end_tab[4]     = BYTE_W'($urandom_range(0, 255));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Noise while hunting, an end delimiter among it
        send_word(8'h00);
        send_word(8'hFF);
        send_word(END_DELIM_RST);
        send_word(8'h5A);
        // Frame with extreme bytes and a start delimiter inside it
        send_word(START_DELIM_RST);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(START_DELIM_RST);
        send_word(8'h80);
        send_word(END_DELIM_RST);
        // Shortest frame: just the two delimiters
        send_word(START_DELIM_RST);
        send_word(END_DELIM_RST);
        settle();

        run_phase(PHASE_WORDS);
        settle();

        // Extremes, equal delimiters, alternating bits, then a random pair
        for (int p = 0; p < 5; p++)
        begin
            configure(start_tab[p], end_tab[p]);
            run_phase(PHASE_WORDS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
